// ----- rtl/prwc_pkg.sv -----
// ----------------------------------------------------------------------------
// prwc_pkg - protected region write checker package
// Shared widths, result codes and the beat types that run along the cell row.
// ----------------------------------------------------------------------------
package prwc_pkg;

    localparam int NUM_REGIONS = 16;
    localparam int ADDR_BITS   = 52;
    localparam int CNT_BITS    = 64;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_DISABLED = 2'd2
    } t_status;

    // one table entry, passed to the next cell when a region is appended
    typedef struct packed {
        logic                 vld;
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] len;
    } t_region;

    // lookup token walking down the row
    typedef struct packed {
        logic                 vld;
        logic [ADDR_BITS-1:0] addr;
        logic                 hit;
    } t_tok;

endpackage

// ----- rtl/prwc_if.sv -----
// ----------------------------------------------------------------------------
// prwc_if - request and result channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface prwc_in_if
    import prwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] region_size;
    logic                 is_write;

    modport source (output valid, func, address, region_size, is_write, input ready);
    modport sink   (input valid, func, address, region_size, is_write, output ready);
endinterface

interface prwc_out_if
    import prwc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic                write_blocked;
    logic [CNT_BITS-1:0] violation_count;

    modport source (output valid, status, write_blocked, violation_count, input ready);
    modport sink   (input valid, status, write_blocked, violation_count, output ready);
endinterface

// ----- rtl/prwc_cell.sv -----
// ----------------------------------------------------------------------------
// prwc_cell - one region slot of the checker row
// Holds one base/length pair, shifts it on append, and tests the passing token.
// ----------------------------------------------------------------------------
module prwc_cell
    import prwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_region i_region,
    output t_region o_region,
    input  t_tok    i_tok,
    output t_tok    o_tok
);

    logic                 r_vld;
    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_len;
    logic                 r_tok_vld;
    logic [ADDR_BITS-1:0] r_tok_addr;
    logic                 r_tok_hit;

    logic [ADDR_BITS-1:0] w_diff;
    logic                 w_match;

    // base <= addr < base + len without forming the sum
    assign w_diff  = i_tok.addr - r_base;
    assign w_match = r_vld && (i_tok.addr >= r_base) && (w_diff < r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            if (i_shift) begin
                r_vld <= i_region.vld;
            end
            r_tok_vld <= i_tok.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_base <= i_region.base;
            r_len  <= i_region.len;
        end
        r_tok_addr <= i_tok.addr;
        r_tok_hit  <= i_tok.hit | (i_tok.vld & w_match);
    end

    assign o_region = '{vld: r_vld, base: r_base, len: r_len};
    assign o_tok    = '{vld: r_tok_vld, addr: r_tok_addr, hit: r_tok_hit};

    // regions are never removed
    a_vld_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |=> r_vld)
        else $error("region slot lost its entry");

endmodule

// ----- rtl/protected_region_write_checker_top.sv -----
// ----------------------------------------------------------------------------
// protected_region_write_checker_top - protected region write checker
// Appends base/length regions to a row of cells and checks fault addresses.
// ----------------------------------------------------------------------------
// Result timing: adds, reads, and any beat while disabled give a result in
//   the cycle after acceptance; an enabled write check walks the cell row (one
//   cell per cycle) and its result is registered as the token leaves the row.
// Throughput: one beat at a time; the next request beat is taken the cycle
//   after the result beat leaves.
// Reset (synchronous, active low): table empty, counter zero, enable set.
// ----------------------------------------------------------------------------
module protected_region_write_checker_top
    import prwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    prwc_in_if.sink     i_in,
    prwc_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    // ------------------------------------------------------------------
    // Control and result registers
    // ------------------------------------------------------------------
    logic                r_busy,     n_busy;      // beat accepted, result not yet taken
    logic                r_chk_busy, n_chk_busy;  // token walking the row
    logic                r_enable;
    logic [CNT_BITS-1:0] r_viol,     n_viol;
    logic                r_out_vld,  n_out_vld;
    t_status             r_out_status,  n_out_status;
    logic                r_out_blocked, n_out_blocked;
    logic [CNT_BITS-1:0] r_out_count,   n_out_count;

    // ------------------------------------------------------------------
    // Cell row: regions enter at cell 0 and shift down on each append,
    // the lookup token enters at cell 0 and moves one cell per cycle.
    // ------------------------------------------------------------------
    t_region region_chain [0:NUM_REGIONS];
    t_tok    tok_chain    [0:NUM_REGIONS];

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;
    logic w_add_go;
    logic w_chk_go;
    logic w_imm;
    logic w_tok_done;
    logic w_viol_inc;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    // the last cell holds an entry only once every slot is used
    assign w_full = region_chain[NUM_REGIONS].vld;

    assign w_add_go = w_in_acc && (i_in.func == FUNC_ADD) && !w_full && r_enable;
    assign w_chk_go = w_in_acc && (i_in.func == FUNC_CHECK) && r_enable && i_in.is_write;
    // everything except an enabled write check is answered at once
    assign w_imm    = w_in_acc && !w_chk_go;

    assign w_tok_done = tok_chain[NUM_REGIONS].vld;
    assign w_viol_inc = w_tok_done && tok_chain[NUM_REGIONS].hit;

    assign region_chain[0] = '{vld: 1'b1, base: i_in.address, len: i_in.region_size};
    assign tok_chain[0]    = '{vld: w_chk_go, addr: i_in.address, hit: 1'b0};

    for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
        prwc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_add_go),
            .i_region (region_chain[g]),
            .o_region (region_chain[g+1]),
            .i_tok    (tok_chain[g]),
            .o_tok    (tok_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_busy        = r_busy;
        n_chk_busy    = r_chk_busy;
        n_viol        = r_viol;
        n_out_vld     = r_out_vld;
        n_out_status  = r_out_status;
        n_out_blocked = r_out_blocked;
        n_out_count   = r_out_count;

        if (w_in_acc) begin
            n_busy = 1'b1;
        end
        if (w_out_acc) begin
            n_busy    = 1'b0;
            n_out_vld = 1'b0;
        end
        if (w_chk_go) begin
            n_chk_busy = 1'b1;
        end

        if (w_imm) begin
            n_out_vld     = 1'b1;
            n_out_blocked = 1'b0;
            n_out_count   = r_viol;
            if (i_in.func == FUNC_ADD) begin
                // full wins over disabled
                if (w_full) begin
                    n_out_status = ST_FULL;
                end else if (!r_enable) begin
                    n_out_status = ST_DISABLED;
                end else begin
                    n_out_status = ST_OK;
                end
            end else begin
                n_out_status = r_enable ? ST_OK : ST_DISABLED;
            end
        end

        if (w_tok_done) begin
            n_chk_busy    = 1'b0;
            n_out_vld     = 1'b1;
            n_out_status  = ST_OK;
            n_out_blocked = w_viol_inc;
            if (w_viol_inc) begin
                n_viol = r_viol + CNT_BITS'(1);   // wraps
            end
            n_out_count = n_viol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_chk_busy <= 1'b0;
            r_enable   <= 1'b1;
            r_viol     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_chk_busy <= n_chk_busy;
            r_viol     <= n_viol;
            r_out_vld  <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_blocked <= n_out_blocked;
        r_out_count   <= n_out_count;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_in.ready            = !r_busy;
    assign o_out.valid           = r_out_vld;
    assign o_out.status          = r_out_status;
    assign o_out.write_blocked   = r_out_blocked;
    assign o_out.violation_count = r_out_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_result_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_vld && r_chk_busy))
        else $error("result beat pending while token still in row");

    a_tok_only_when_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_done |-> r_chk_busy)
        else $error("token left the row with no check in flight");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_viol_inc |=> $stable(r_viol))
        else $error("violation counter moved without a blocked write");

    a_no_append_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_go |-> !w_full && r_enable)
        else $error("region appended to a full or disabled table");

    a_one_beat_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld || r_chk_busy) |-> !i_in.ready)
        else $error("request taken while previous beat in progress");

endmodule
